// ----- rtl/bcld_pkg.sv -----
`timescale 1ns / 1ps

package bcld_pkg;

    localparam int TAG_W   = 32;
    localparam int STAMP_W = 64;
    localparam int SLOT_W  = 6;

    // A slot that has been handed out and not yet released carries this stamp.
    localparam logic [STAMP_W-1:0] STAMP_BUSY = {STAMP_W{1'b1}};

    localparam logic REQ_GET     = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Input tdata, lowest bit first: block_pos, slot_in, dirty, pad.
    typedef struct packed {
        logic              pad;
        logic              dirty;
        logic [SLOT_W-1:0] slot_in;
        logic [TAG_W-1:0]  block_pos;
    } in_data_t;

    // Output tdata, lowest bit first: hit, slot_out, fetch_needed, write_back,
    // backing_pos, victim_busy, pad.
    typedef struct packed {
        logic [5:0]        pad;
        logic              victim_busy;
        logic [TAG_W-1:0]  backing_pos;
        logic              write_back;
        logic              fetch_needed;
        logic [SLOT_W-1:0] slot_out;
        logic              hit;
    } out_data_t;

    // Control from the sequencer to the scan unit.
    typedef struct packed {
        logic start;
        logic issue;
    } scan_ctl_t;

    // Status from the scan unit back to the sequencer.
    typedef struct packed {
        logic hit;
        logic busy;
    } scan_stat_t;

endpackage

// ----- rtl/bcld_ram.sv -----
`timescale 1ns / 1ps

module bcld_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/bcld_scan.sv -----
`timescale 1ns / 1ps

module bcld_scan
    import bcld_pkg::*;
#(
    parameter int NUM_SLOTS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  scan_ctl_t                    ctl,
    input  logic [$clog2(NUM_SLOTS)-1:0] idx,
    input  logic [TAG_W-1:0]             pos,
    input  logic [TAG_W-1:0]             tag_data,
    input  logic [STAMP_W-1:0]           stamp_data,
    output scan_stat_t                   stat,
    output logic [$clog2(NUM_SLOTS)-1:0] hit_idx,
    output logic [$clog2(NUM_SLOTS)-1:0] min_idx
);

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic             vld_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             min_valid_reg;
    logic [IDX_W-1:0] min_idx_reg;
    logic [STAMP_W-1:0] min_stamp_reg;

    // The index is delayed so that it lines up with the registered RAM read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= ctl.issue;
        end
        idx_reg <= idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.start) begin
            hit_reg       <= 1'b0;
            min_valid_reg <= 1'b0;
        end else if (vld_reg) begin
            // Only the first match counts; strict compare keeps the lowest
            // slot on a tie of stamps.
            if (!hit_reg && tag_data == pos) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= idx_reg;
            end
            if (!min_valid_reg || stamp_data < min_stamp_reg) begin
                min_valid_reg <= 1'b1;
                min_idx_reg   <= idx_reg;
                min_stamp_reg <= stamp_data;
            end
        end
    end

    assign stat.hit  = hit_reg;
    assign stat.busy = min_stamp_reg == STAMP_BUSY;
    assign hit_idx   = hit_idx_reg;
    assign min_idx   = min_idx_reg;

endmodule

// ----- rtl/block_cache_lru_directory.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata: block_pos, slot_in, dirty
//                                              tuser: req_type
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata: hit, slot_out, fetch_needed,
//                                              write_back, backing_pos, victim_busy
//
// One request is worked on at a time. A get on a nonempty directory passes through
// the states SCAN, WAIT, DECIDE and OUT; the scan reads one tag and one stamp per cycle
// from the two RAMs, one slot after another up to the fill count. A get on an empty
// directory goes from IDLE to DECIDE and then OUT, and a release to REL and then OUT.
// Reset clears the fill count, the release counter, the scan index, the state, the output
// valid flag and the scan unit's flags; the RAMs need no clearing since only filled slots are ever used.
// A stalled result sits in the output register while the next request is taken.

module block_cache_lru_directory
    import bcld_pkg::*;
#(
    parameter int NUM_SLOTS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // block_pos, slot_in, dirty, zero pad
    input  logic        s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // hit, slot_out, fetch_needed, write_back,
                                        // backing_pos, victim_busy, zero pad
);

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int WIDE_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CMP_W  = CNT_W + SLOT_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_REL    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   fill_reg;
    logic [STAMP_W-1:0] release_counter_reg;
    logic [IDX_W-1:0]   scan_cnt_reg;
    logic [TAG_W-1:0]   pos_reg;
    logic [IDX_W-1:0]   rel_idx_reg;
    logic [SLOT_W-1:0]  rel_slot_reg;
    logic               rel_ok_reg;
    logic               dirty_reg;
    out_data_t          res_reg;
    out_data_t          res_next;
    out_data_t          m_data_reg;
    logic               m_valid_reg;

    in_data_t           in_data;
    logic               s_xfer;
    logic               scan_last;
    logic               full;
    logic [WIDE_W-1:0]  slot_in_wide;
    logic [IDX_W-1:0]   slot_in_idx;
    logic               slot_in_ok;
    logic [IDX_W-1:0]   victim_idx;
    logic [WIDE_W-1:0]  victim_wide;

    logic               tag_wr_en;
    logic               stamp_wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [STAMP_W-1:0] stamp_wr_data;
    logic               tag_rd_en;
    logic [IDX_W-1:0]   tag_rd_addr;
    logic [TAG_W-1:0]   tag_rd_data;
    logic [STAMP_W-1:0] stamp_rd_data;

    scan_ctl_t          scan_ctl;
    scan_stat_t         scan_stat;
    logic [IDX_W-1:0]   hit_idx;
    logic [IDX_W-1:0]   min_idx;

    assign in_data      = in_data_t'(s_axis_tdata);
    assign s_axis_tready = state_reg == ST_IDLE;
    assign s_xfer       = s_axis_tvalid && s_axis_tready;

    assign slot_in_wide = WIDE_W'(in_data.slot_in);
    assign slot_in_idx  = slot_in_wide[IDX_W-1:0];
    assign slot_in_ok   = CMP_W'(in_data.slot_in) < CMP_W'(fill_reg);

    assign scan_last    = CNT_W'(scan_cnt_reg) == fill_reg - CNT_W'(1);
    assign full         = fill_reg == CNT_W'(NUM_SLOTS);
    assign victim_idx   = full ? min_idx : fill_reg[IDX_W-1:0];
    assign victim_wide  = WIDE_W'(victim_idx);

    // Reads are only issued from IDLE and SCAN, and writes only in DECIDE and
    // REL, so a read never meets a write to the same slot in flight.
    assign tag_rd_en    = (state_reg == ST_IDLE) || (state_reg == ST_SCAN);
    assign tag_rd_addr  = (state_reg == ST_IDLE) ? slot_in_idx : scan_cnt_reg;

    always_comb begin
        tag_wr_en     = 1'b0;
        stamp_wr_en   = 1'b0;
        wr_addr       = victim_idx;
        stamp_wr_data = STAMP_BUSY;
        case (state_reg)
            ST_DECIDE: begin
                tag_wr_en   = !scan_stat.hit;
                stamp_wr_en = !scan_stat.hit;
            end
            ST_REL: begin
                stamp_wr_en   = rel_ok_reg;
                wr_addr       = rel_idx_reg;
                stamp_wr_data = release_counter_reg;
            end
            default: begin
            end
        endcase
    end

    assign scan_ctl.start = s_xfer;
    assign scan_ctl.issue = state_reg == ST_SCAN;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_axis_tuser == REQ_RELEASE) begin
                        state_next = ST_REL;
                    end else if (fill_reg == '0) begin
                        state_next = ST_DECIDE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:   state_next = ST_DECIDE;
            ST_DECIDE: state_next = ST_OUT;
            ST_REL:    state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            fill_reg            <= '0;
            release_counter_reg <= '0;
            scan_cnt_reg        <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_xfer) begin
                scan_cnt_reg <= '0;
            end else if (state_reg == ST_SCAN) begin
                scan_cnt_reg <= scan_cnt_reg + IDX_W'(1);
            end
            if (state_reg == ST_DECIDE && !scan_stat.hit && !full) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end
            if (state_reg == ST_REL && rel_ok_reg) begin
                release_counter_reg <= release_counter_reg + STAMP_W'(1);
            end
            if (state_reg == ST_OUT && (!m_valid_reg || m_axis_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        res_next = res_reg;
        if (state_reg == ST_DECIDE) begin
            res_next = '0;
            if (scan_stat.hit) begin
                res_next.hit      = 1'b1;
                res_next.slot_out = SLOT_W'(hit_idx);
            end else begin
                res_next.slot_out     = victim_wide[SLOT_W-1:0];
                res_next.fetch_needed = 1'b1;
                res_next.backing_pos  = pos_reg;
                res_next.victim_busy  = full && scan_stat.busy;
            end
        end else if (state_reg == ST_REL) begin
            res_next          = '0;
            res_next.slot_out = rel_slot_reg;
            if (rel_ok_reg && dirty_reg) begin
                res_next.write_back  = 1'b1;
                res_next.backing_pos = tag_rd_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pos_reg      <= in_data.block_pos;
            rel_idx_reg  <= slot_in_idx;
            rel_slot_reg <= in_data.slot_in;
            rel_ok_reg   <= slot_in_ok;
            dirty_reg    <= in_data.dirty;
        end
        res_reg <= res_next;
        if (state_reg == ST_OUT && (!m_valid_reg || m_axis_tready)) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    bcld_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (tag_wr_en),
        .wr_addr (wr_addr),
        .wr_data (pos_reg),
        .rd_en   (tag_rd_en),
        .rd_addr (tag_rd_addr),
        .rd_data (tag_rd_data)
    );

    bcld_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (NUM_SLOTS)
    ) u_stamp_ram (
        .aclk    (aclk),
        .wr_en   (stamp_wr_en),
        .wr_addr (wr_addr),
        .wr_data (stamp_wr_data),
        .rd_en   (scan_ctl.issue),
        .rd_addr (scan_cnt_reg),
        .rd_data (stamp_rd_data)
    );

    bcld_scan #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (scan_ctl),
        .idx        (scan_cnt_reg),
        .pos        (pos_reg),
        .tag_data   (tag_rd_data),
        .stamp_data (stamp_rd_data),
        .stat       (scan_stat),
        .hit_idx    (hit_idx),
        .min_idx    (min_idx)
    );

endmodule

// ----- rtl/bcld_checker.sv -----
`timescale 1ns / 1ps

module bcld_checker
    import bcld_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    out_data_t  out_data;
    logic       s_xfer;
    logic       m_xfer;
    logic [1:0] pending_reg;

    assign out_data = out_data_t'(m_axis_tdata);
    assign s_xfer   = s_axis_tvalid && s_axis_tready;
    assign m_xfer   = m_axis_tvalid && m_axis_tready;

    // Requests taken minus results delivered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (s_xfer && !m_xfer) begin
            pending_reg <= pending_reg + 2'd1;
        end else if (m_xfer && !s_xfer) begin
            pending_reg <= pending_reg - 2'd1;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_no_extra_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> pending_reg != 2'd0)
        else $error("result shown with no request outstanding");

    a_pending_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_data.hit |->
            !out_data.fetch_needed && !out_data.write_back &&
            !out_data.victim_busy && out_data.backing_pos == '0)
        else $error("hit result carries fetch or write-back data");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind block_cache_lru_directory bcld_checker u_bcld_checker (.*);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import bcld_pkg::*;

    localparam int NUM_SLOTS   = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_WAIT  = 2 * NUM_SLOTS + 16;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // block_pos, slot_in, dirty, zero pad
    logic        s_axis_tuser;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // hit, slot_out, fetch_needed, write_back,
                                 // backing_pos, victim_busy, zero pad

    // Directory state as the bench expects it to be.
    logic [TAG_W-1:0]   dir_tag [NUM_SLOTS];
    logic [STAMP_W-1:0] dir_stamp [NUM_SLOTS];
    int                 dir_fill;
    logic [STAMP_W-1:0] release_ctr;

    out_data_t directory_replies[$];
    int        mismatches;
    int        cycle_count;
    bit        quiet;
    bit        hold_request;

    block_cache_lru_directory #(
        .NUM_SLOTS(NUM_SLOTS)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Applies one accepted request to the directory and returns the reply it must give.
    function automatic out_data_t directory_step(logic req, logic [TAG_W-1:0] pos,
                                                 logic [SLOT_W-1:0] slot, logic dirty);
        out_data_t r;
        int        found;
        int        victim;
        r = '0;
        found = -1;
        if (req == REQ_GET) begin
            for (int i = 0; i < dir_fill; i++) begin
                if (found < 0 && dir_tag[i] == pos) found = i;
            end
            if (found >= 0) begin
                r.hit = 1'b1;
                r.slot_out = SLOT_W'(found);
            end else begin
                if (dir_fill < NUM_SLOTS) begin
                    victim = dir_fill;
                    dir_fill++;
                end else begin
                    // Strict compare keeps the lowest slot on a tie.
                    victim = 0;
                    for (int i = 1; i < NUM_SLOTS; i++) begin
                        if (dir_stamp[i] < dir_stamp[victim]) victim = i;
                    end
                    r.victim_busy = (dir_stamp[victim] == STAMP_BUSY);
                end
                dir_tag[victim] = pos;
                dir_stamp[victim] = STAMP_BUSY;
                r.slot_out = SLOT_W'(victim);
                r.fetch_needed = 1'b1;
                r.backing_pos = pos;
            end
        end else begin
            r.slot_out = slot;
            if (int'(slot) < dir_fill) begin
                if (dirty) begin
                    r.write_back = 1'b1;
                    r.backing_pos = dir_tag[slot];
                end
                dir_stamp[slot] = release_ctr;
                release_ctr = release_ctr + 1'b1;
            end
        end
        return r;
    endfunction

    // Offers one request after a random gap and waits for its transfer.
    task automatic send_request(logic req, logic [TAG_W-1:0] pos,
                                logic [SLOT_W-1:0] slot, logic dirty);
        in_data_t word;
        int       gap;
        word = '0;
        word.block_pos = pos;
        word.slot_in = slot;
        word.dirty = dirty;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= req;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        directory_replies.push_back(directory_step(req, pos, slot, dirty));
    endtask

    task automatic send_get(logic [TAG_W-1:0] pos);
        send_request(REQ_GET, pos, SLOT_W'($urandom), 1'($urandom));
    endtask

    task automatic send_release(logic [SLOT_W-1:0] slot, logic dirty);
        send_request(REQ_RELEASE, $urandom, slot, dirty);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_reply();
        out_data_t got;
        out_data_t want;
        got = m_axis_tdata;
        if (directory_replies.size() == 0) begin
            $display("%0t: reply with nothing pending, expected none, actual %0h",
                     $time, got);
            mismatches++;
        end else begin
            want = directory_replies.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("slot_out", want.slot_out, got.slot_out);
            compare_field("fetch_needed", want.fetch_needed, got.fetch_needed);
            compare_field("write_back", want.write_back, got.write_back);
            compare_field("backing_pos", want.backing_pos, got.backing_pos);
            compare_field("victim_busy", want.victim_busy, got.victim_busy);
        end
    endtask

    // Result side: checks every transfer and stalls at random or on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) check_reply();
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 9) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Small fills, hits, releases clean and dirty, and releases of slots not yet filled.
    task automatic test_basic_requests();
        quiet = 1'b1;
        send_get(32'h0000_0000);
        send_get(32'hFFFF_FFFF);
        send_get(32'hA5A5_A5A5);
        send_get(32'hFFFF_FFFF);
        send_release(6'd1, 1'b1);
        send_release(6'd0, 1'b0);
        send_release(6'd2, 1'b1);
        send_release(6'd3, 1'b1);
        send_release(6'd63, 1'b1);
        // A slot that is not held gets a fresh stamp all the same.
        send_release(6'd1, 1'b0);
        send_get(32'h0000_0000);
        quiet = 1'b0;
    endtask

    task automatic test_fill_directory();
        while (dir_fill < NUM_SLOTS) send_get($urandom);
    endtask

    // Evictions on a full directory: oldest release first, then every slot held,
    // then the last slot as the only released one, then a miss and a hit on one tag.
    task automatic test_full_eviction();
        repeat (4) send_get($urandom);
        send_release(6'd63, 1'b1);
        send_get($urandom);
        send_get(32'h5A5A_5A5A);
        send_get(32'h5A5A_5A5A);
    endtask

    task automatic random_request(int release_pct);
        if ($urandom_range(0, 99) < release_pct) begin
            send_release(SLOT_W'($urandom_range(0, NUM_SLOTS - 1)), 1'($urandom));
        end else if ($urandom_range(0, 99) < 65) begin
            send_get(dir_tag[$urandom_range(0, dir_fill - 1)]);
        end else begin
            send_get($urandom);
        end
    endtask

    // The result side holds off while requests keep coming, so the input must stall.
    task automatic test_output_backpressure();
        quiet = 1'b1;
        hold_request = 1'b1;
        repeat (20) random_request(30);
        quiet = 1'b0;
    endtask

    task automatic test_random_traffic();
        int release_pct;
        for (int chunk = 0; chunk < 18; chunk++) begin
            release_pct = $urandom_range(5, 70);
            quiet = (chunk % 5 == 3);
            repeat (100) random_request(release_pct);
        end
        quiet = 1'b0;
    endtask

    initial begin
        mismatches = 0;
        dir_fill = 0;
        release_ctr = '0;
        quiet = 1'b0;
        hold_request = 1'b0;
        aresetn <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= REQ_GET;
        m_axis_tready <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_basic_requests();
        test_fill_directory();
        test_full_eviction();
        test_output_backpressure();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (directory_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
